// File: rtl/layer_norm_row_defines.svh
// ----------------------------------------------------------------------------
// layer_norm_row_defines: assertion macros
// Shared concurrent assertion forms for the layer_norm_row checkers.
// ----------------------------------------------------------------------------
`ifndef LAYER_NORM_ROW_DEFINES_SVH
`define LAYER_NORM_ROW_DEFINES_SVH

// same-cycle implication, reset masked
`define LNR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, reset masked
`define LNR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/lnr_pkg.sv
// ----------------------------------------------------------------------------
// lnr_pkg: layer_norm_row shared definitions
// Widths, register indexes, controller states and command/status groups.
// ----------------------------------------------------------------------------
`default_nettype none
package lnr_pkg;

  localparam int MAX_ROW_DEF = 64;
  localparam int LEN_W       = 7;
  localparam int SMP_W       = 16;
  localparam int EPS_W       = 16;
  localparam int DIV_NW      = 49;
  localparam int DIV_DW      = 32;
  localparam int SQ_W        = 50;
  localparam int ROOT_W      = SQ_W / 2;

  typedef enum logic [1:0] {
    REG_ROW_LENGTH = 2'd0,
    REG_EPSILON    = 2'd1,
    REG_USE_WEIGHT = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    DSEL_VAR,
    DSEL_Q,
    DSEL_REC
  } div_sel_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PREP,
    ST_SUB,
    ST_VAR_GO,
    ST_VAR_WT,
    ST_VSUM,
    ST_Q_GO,
    ST_Q_WT,
    ST_SQ_GO,
    ST_SQ_WT,
    ST_REC_GO,
    ST_REC_WT,
    ST_RD,
    ST_O1,
    ST_O2,
    ST_O3,
    ST_O4,
    ST_O5,
    ST_O6,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic     in_acc;
    logic     prep;
    logic     sub;
    logic     div_go;
    div_sel_t div_sel;
    logic     ld_var;
    logic     inv_sat;
    logic     sq_go;
    logic     ld_inv;
    logic     ld_rec;
    logic     rd;
    logic     s1;
    logic     s2;
    logic     s3;
    logic     s4;
    logic     s5;
    logic     s6;
    logic     out_adv;
  } cmd_t;

  typedef struct packed {
    logic row_done;
    logic div_busy;
    logic sq_busy;
    logic v_zero;
    logic last_idx;
  } status_t;

endpackage
`default_nettype wire

// File: rtl/lnr_div.sv
// ----------------------------------------------------------------------------
// lnr_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module lnr_div #(
  parameter int NW = 49,
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          go,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               busy,
  output logic [NW-1:0]      quo
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [DW-1:0]    rem;
  logic [DW-1:0]    dvs;
  logic [CNT_W-1:0] cnt;
  logic [DW:0]      trial;
  logic             ge;

  assign trial = {rem, quo[NW-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (go) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= ge ? DW'(trial - {1'b0, dvs}) : trial[DW-1:0];
      quo <= {quo[NW-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// File: rtl/lnr_sqrt.sv
// ----------------------------------------------------------------------------
// lnr_sqrt: iterative integer square root
// Digit-by-digit floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module lnr_sqrt #(
  parameter int W = 50
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           go,
  input  wire logic [W-1:0]   radicand,
  output logic                busy,
  output logic [W/2-1:0]      root
);

  localparam int RW    = W / 2;
  localparam int CNT_W = $clog2(RW + 1);

  logic [W-1:0]     rad;
  logic [RW:0]      rem;
  logic [CNT_W-1:0] cnt;
  logic [RW+2:0]    cand;
  logic [RW+2:0]    trial;
  logic             ge;

  assign cand  = {rem, rad[W-1:W-2]};
  assign trial = {1'b0, root, 2'b01};
  assign ge    = cand >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (go) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(RW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[W-3:0], 2'b00};
      rem  <= ge ? (RW+1)'(cand - trial) : cand[RW:0];
      root <= {root[RW-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// File: rtl/lnr_datapath.sv
// ----------------------------------------------------------------------------
// lnr_datapath: layer_norm_row datapath
// Row buffers, running sums, statistics, scale factor and output pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
module lnr_datapath #(
  parameter int MAX_ROW = lnr_pkg::MAX_ROW_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire lnr_pkg::cmd_t                cmd,
  output lnr_pkg::status_t                  sts,
  input  wire logic signed [lnr_pkg::SMP_W-1:0] in_sample,
  input  wire logic signed [lnr_pkg::SMP_W-1:0] in_weight,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [15:0]                  cfg_data,
  output logic [lnr_pkg::SMP_W-1:0]         out_value,
  output logic                              last_of_row
);
  import lnr_pkg::*;

  localparam int AW = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;
  localparam int CW = $clog2(MAX_ROW + 1);

  logic [LEN_W-1:0] rl_r;
  logic [EPS_W-1:0] eps_r;
  logic             uw_r;

  logic [SMP_W-1:0] sample_mem [MAX_ROW];
  logic [SMP_W-1:0] weight_mem [MAX_ROW];

  logic [CW-1:0]        fill_r;
  logic [LEN_W-1:0]     len;
  logic [LEN_W-1:0]     n_in;
  logic [LEN_W-1:0]     n_r;
  logic signed [21:0]   sum_r;
  logic [36:0]          sumsq_r;
  logic signed [31:0]   sq;
  logic [43:0]          a_r;
  logic [43:0]          b_r;
  logic signed [43:0]   bb;
  logic [12:0]          nn_r;
  logic [43:0]          s2_r;
  logic [DIV_DW-1:0]    v_r;
  logic [ROOT_W-1:0]    inv_r;
  logic [28:0]          rec_r;
  logic [AW-1:0]        idx_r;

  logic [DIV_NW-1:0]    div_n;
  logic [DIV_DW-1:0]    div_d;
  logic                 div_busy;
  logic [DIV_NW-1:0]    div_q;
  logic                 sq_busy;
  logic [ROOT_W-1:0]    sq_root;

  logic signed [SMP_W-1:0] x_r;
  logic signed [SMP_W-1:0] w_r;
  logic signed [22:0]      d_r;
  logic signed [48:0]      p_full;
  logic signed [47:0]      p_r;
  logic signed [63:0]      pw;
  logic signed [63:0]      pw_r;
  logic                    neg_r;
  logic [63:0]             mag;
  logic [63:0]             rnd;
  logic [39:0]             tt;
  logic [21:0]             t_r;
  logic [50:0]             qq;
  logic [22:0]             q_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rl_r  <= LEN_W'(64);
      eps_r <= EPS_W'(1);
      uw_r  <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROW_LENGTH: rl_r  <= cfg_data[LEN_W-1:0];
        REG_EPSILON:    eps_r <= cfg_data[EPS_W-1:0];
        REG_USE_WEIGHT: uw_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (rl_r == '0) begin
      len = LEN_W'(1);
    end else if (rl_r > LEN_W'(MAX_ROW)) begin
      len = LEN_W'(MAX_ROW);
    end else begin
      len = rl_r;
    end
  end

  assign n_in = LEN_W'(fill_r) + LEN_W'(1);
  assign sq   = in_sample * in_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_r <= '0;
    end else if (cmd.in_acc) begin
      fill_r <= (n_in >= len) ? '0 : CW'(n_in);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_acc) begin
      sample_mem[fill_r[AW-1:0]] <= in_sample;
      weight_mem[fill_r[AW-1:0]] <= in_weight;
      sum_r   <= ((fill_r == '0) ? 22'sd0 : sum_r) + 22'(in_sample);
      sumsq_r <= ((fill_r == '0) ? 37'd0 : sumsq_r) + 37'($unsigned(sq));
      if (n_in >= len) begin
        n_r <= n_in;
      end
    end
    if (cmd.rd) begin
      x_r <= sample_mem[idx_r];
      w_r <= weight_mem[idx_r];
    end
  end

  assign bb = 44'(sum_r) * 44'(sum_r);

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      a_r  <= 44'(n_r) * sumsq_r;
      b_r  <= $unsigned(bb);
      nn_r <= 13'(14'(n_r) * 14'(n_r));
    end
    if (cmd.sub) begin
      s2_r <= a_r - b_r;
    end
    if (cmd.ld_var) begin
      v_r <= div_q[DIV_DW-1:0] + DIV_DW'(eps_r);
    end
    if (cmd.inv_sat) begin
      inv_r <= ROOT_W'(1) << 24;
    end else if (cmd.ld_inv) begin
      inv_r <= sq_root;
    end
    if (cmd.ld_rec) begin
      rec_r <= div_q[28:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_rec) begin
      idx_r <= '0;
    end else if (cmd.out_adv) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_comb begin
    case (cmd.div_sel)
      DSEL_VAR: begin
        div_n = DIV_NW'(s2_r);
        div_d = DIV_DW'(nn_r);
      end
      DSEL_Q: begin
        div_n = DIV_NW'(1) << 48;
        div_d = v_r;
      end
      DSEL_REC: begin
        div_n = (DIV_NW'(1) << 28) + DIV_NW'(n_r) - DIV_NW'(1);
        div_d = DIV_DW'(n_r);
      end
      default: begin
        div_n = DIV_NW'(s2_r);
        div_d = DIV_DW'(nn_r);
      end
    endcase
  end

  lnr_div #(
    .NW (DIV_NW),
    .DW (DIV_DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.div_go),
    .dividend (div_n),
    .divisor  (div_d),
    .busy     (div_busy),
    .quo      (div_q)
  );

  lnr_sqrt #(
    .W (SQ_W)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.sq_go),
    .radicand (SQ_W'(div_q)),
    .busy     (sq_busy),
    .root     (sq_root)
  );

  assign p_full = d_r * $signed({1'b0, inv_r});
  assign pw     = uw_r ? (64'(p_r) * 64'(w_r)) : (64'(p_r) <<< 8);
  assign mag    = pw_r[63] ? 64'(-pw_r) : 64'(pw_r);
  assign rnd    = mag + (64'(n_r) << 23);
  assign tt     = rnd[63:24];
  assign qq     = 51'(t_r) * 51'(rec_r);

  always_ff @(posedge clk) begin
    if (cmd.s1) begin
      d_r <= 23'($signed({1'b0, n_r})) * 23'(x_r) - 23'(sum_r);
    end
    if (cmd.s2) begin
      p_r <= p_full[47:0];
    end
    if (cmd.s3) begin
      pw_r <= pw;
    end
    if (cmd.s4) begin
      neg_r <= pw_r[63];
      t_r   <= (tt >= (40'd1 << 22)) ? 22'h3FFFFF : tt[21:0];
    end
    if (cmd.s5) begin
      q_r <= qq[50:28];
    end
    if (cmd.s6) begin
      if (neg_r) begin
        out_value <= (q_r > 23'd32768) ? 16'h8000 : 16'(~q_r + 23'd1);
      end else begin
        out_value <= (q_r > 23'd32767) ? 16'h7FFF : q_r[15:0];
      end
      last_of_row <= sts.last_idx;
    end
  end

  assign sts.row_done = n_in >= len;
  assign sts.div_busy = div_busy;
  assign sts.sq_busy  = sq_busy;
  assign sts.v_zero   = v_r == '0;
  assign sts.last_idx = (LEN_W'(idx_r) + LEN_W'(1)) == n_r;

endmodule
`default_nettype wire

// File: rtl/lnr_ctrl.sv
// ----------------------------------------------------------------------------
// lnr_ctrl: layer_norm_row controller
// Sequences buffering, statistics, scale factor and row emission.
// ----------------------------------------------------------------------------
`default_nettype none
module lnr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lnr_pkg::status_t  sts,
  output lnr_pkg::cmd_t          cmd,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready
);
  import lnr_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid && sts.row_done) state_next = ST_PREP;
      ST_PREP:   state_next = ST_SUB;
      ST_SUB:    state_next = ST_VAR_GO;
      ST_VAR_GO: state_next = ST_VAR_WT;
      ST_VAR_WT: if (!sts.div_busy) state_next = ST_VSUM;
      ST_VSUM:   state_next = ST_Q_GO;
      ST_Q_GO:   state_next = sts.v_zero ? ST_REC_GO : ST_Q_WT;
      ST_Q_WT:   if (!sts.div_busy) state_next = ST_SQ_GO;
      ST_SQ_GO:  state_next = ST_SQ_WT;
      ST_SQ_WT:  if (!sts.sq_busy) state_next = ST_REC_GO;
      ST_REC_GO: state_next = ST_REC_WT;
      ST_REC_WT: if (!sts.div_busy) state_next = ST_RD;
      ST_RD:     state_next = ST_O1;
      ST_O1:     state_next = ST_O2;
      ST_O2:     state_next = ST_O3;
      ST_O3:     state_next = ST_O4;
      ST_O4:     state_next = ST_O5;
      ST_O5:     state_next = ST_O6;
      ST_O6:     state_next = ST_EMIT;
      ST_EMIT:   if (out_ready) state_next = sts.last_idx ? ST_IDLE : ST_RD;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.div_sel = DSEL_VAR;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.in_acc = in_valid;
      end
      ST_PREP:   cmd.prep = 1'b1;
      ST_SUB:    cmd.sub  = 1'b1;
      ST_VAR_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DSEL_VAR;
      end
      ST_VSUM:   cmd.ld_var = 1'b1;
      ST_Q_GO: begin
        cmd.inv_sat = sts.v_zero;
        cmd.div_go  = !sts.v_zero;
        cmd.div_sel = DSEL_Q;
      end
      ST_SQ_GO:  cmd.sq_go = 1'b1;
      ST_SQ_WT:  cmd.ld_inv = !sts.sq_busy;
      ST_REC_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DSEL_REC;
      end
      ST_REC_WT: cmd.ld_rec = !sts.div_busy;
      ST_RD:     cmd.rd = 1'b1;
      ST_O1:     cmd.s1 = 1'b1;
      ST_O2:     cmd.s2 = 1'b1;
      ST_O3:     cmd.s3 = 1'b1;
      ST_O4:     cmd.s4 = 1'b1;
      ST_O5:     cmd.s5 = 1'b1;
      ST_O6:     cmd.s6 = 1'b1;
      ST_EMIT: begin
        out_valid   = 1'b1;
        cmd.out_adv = out_ready;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/layer_norm_row.sv
// ----------------------------------------------------------------------------
// layer_norm_row: row layer normalisation, Q8.8
// Buffers a row, derives mean, variance and inverse root, emits the row.
// ----------------------------------------------------------------------------
// Samples are taken one a cycle until a row completes; the block then stops
// taking input while one shared 49-step divider works out the variance,
// 2^48 over (variance + epsilon) and a reciprocal of the row length, and a
// 25-step root unit gives the scale factor. Each result then steps through
// the output sequencer states ST_RD, ST_O1 to ST_O6 and ST_EMIT, waiting in
// ST_EMIT on m_tready. Input is not taken while a row is being emitted.
// Configuration writes are always accepted.
`default_nettype none
module layer_norm_row #(
  parameter int MAX_ROW = lnr_pkg::MAX_ROW_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // sample[15:0], weight[31:16]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // out_value[15:0]
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import lnr_pkg::*;

  cmd_t    cmd;
  status_t sts;

  lnr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .sts       (sts),
    .cmd       (cmd),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready)
  );

  lnr_datapath #(
    .MAX_ROW (MAX_ROW)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_sample   ($signed(s_tdata[15:0])),
    .in_weight   ($signed(s_tdata[31:16])),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_value   (m_tdata),
    .last_of_row (m_tlast)
  );

endmodule
`default_nettype wire

// File: rtl/lnr_checker.sv
// ----------------------------------------------------------------------------
// lnr_checker: layer_norm_row port checks
// Concurrent assertions on the stream ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "layer_norm_row_defines.svh"
module lnr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic        m_tlast
);

  `LNR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result dropped or changed while stalled")
  `LNR_ASSERT_NOW(a_no_in_during_out, m_tvalid, !s_tready, "input taken while a result is pending")
  `LNR_ASSERT_NEXT(a_last_idle, m_tvalid && m_tready && m_tlast, !m_tvalid && s_tready, "block not idle after end of row")

endmodule

bind layer_norm_row lnr_checker u_lnr_checker (.*);
`default_nettype wire
